// File: design/y2bgr_pkg.sv
// Shared constants and color arithmetic for the YUYV to BGR converter.
package y2bgr_pkg;

  localparam int ADDR_W = 23;
  localparam int CFG_W  = 11;
  localparam int SUM_W  = 21;

  localparam logic [CFG_W-1:0] PAIRS_RESET = 11'd320;
  localparam logic [CFG_W-1:0] ROWS_RESET  = 11'd480;

  // register indexes (paddr[2])
  localparam logic REG_PAIRS = 1'b0;
  localparam logic REG_ROWS  = 1'b1;

  // cycles the geometry pipeline needs before the frame restarts
  localparam logic [2:0] RESTART_CYCLES = 3'd4;

  // Q2.10 coefficients
  localparam logic signed [SUM_W-1:0] COEF_RV = 21'sd1436;
  localparam logic signed [SUM_W-1:0] COEF_GU = 21'sd352;
  localparam logic signed [SUM_W-1:0] COEF_GV = 21'sd731;
  localparam logic signed [SUM_W-1:0] COEF_BU = 21'sd1815;

  // remove the 128 offset from a chroma sample
  function automatic logic signed [8:0] chroma_offset(input logic [7:0] c);
    chroma_offset = $signed({1'b0, c}) - 9'sd128;
  endfunction

  // sum at 1/1024 scale: zero at or below zero, else floor and clamp to 255
  function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s <= 0) begin
      res = 8'd0;
    end else if (|s[19:18]) begin
      res = 8'hFF;
    end else begin
      res = s[17:10];
    end
    to_byte = res;
  endfunction

  function automatic logic signed [SUM_W-1:0] luma_scaled(input logic [7:0] y);
    luma_scaled = $signed({3'b000, y, 10'b0});
  endfunction

  function automatic logic [7:0] blue_of(input logic [7:0] y, input logic signed [8:0] u);
    logic signed [SUM_W-1:0] uw;
    uw = SUM_W'(u);
    blue_of = to_byte(luma_scaled(y) + COEF_BU * uw);
  endfunction

  function automatic logic [7:0] green_of(input logic [7:0] y, input logic signed [8:0] u,
                                          input logic signed [8:0] v);
    logic signed [SUM_W-1:0] uw;
    logic signed [SUM_W-1:0] vw;
    uw = SUM_W'(u);
    vw = SUM_W'(v);
    green_of = to_byte(luma_scaled(y) - COEF_GU * uw - COEF_GV * vw);
  endfunction

  function automatic logic [7:0] red_of(input logic [7:0] y, input logic signed [8:0] v);
    logic signed [SUM_W-1:0] vw;
    vw = SUM_W'(v);
    red_of = to_byte(luma_scaled(y) + COEF_RV * vw);
  endfunction

endpackage

// File: design/yuyv_to_bgr_frame_flip.sv
// YUYV pixel pair to BGR converter with bottom-up frame store addressing.
//
//  port group   direction  handshake        payload
//  in_*         input      in_valid/ready   luma_first, chroma_blue, luma_second, chroma_red
//  out_*        output     out_valid/ready  bgr of both pixels, byte_address, frame_end
//  APB          slave      psel/penable     pairs_per_row @0x0, rows_per_frame @0x4
//
// One pair per cycle while out_ready is high and no restart is pending; pairs pass the
// input and result registers. After reset and every register write the frame geometry
// goes through a short pipeline (clamp, pair size, multiply); in_ready is low meanwhile.
// A stalled output holds the result; the input register keeps filling until it is full.
module yuyv_to_bgr_frame_flip #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_PAIRS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_luma_first,
  input  logic [7:0]  in_chroma_blue,
  input  logic [7:0]  in_luma_second,
  input  logic [7:0]  in_chroma_red,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue_first,
  output logic [7:0]  out_green_first,
  output logic [7:0]  out_red_first,
  output logic [7:0]  out_blue_second,
  output logic [7:0]  out_green_second,
  output logic [7:0]  out_red_second,
  output logic [22:0] out_byte_address,
  output logic        out_frame_end,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = y2bgr_pkg::ADDR_W;
  localparam int CFW = y2bgr_pkg::CFG_W;
  localparam int PCW = $clog2(MAX_PAIRS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_PAIRS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int PBW = PCW + 3;

  // configuration
  logic [CFW-1:0] cfg_pairs_r;
  logic [CFW-1:0] cfg_rows_r;
  logic           cfg_wr;

  // geometry pipeline
  logic [PCW-1:0] eff_pairs_r;
  logic [PCW-1:0] eff_pairs_nxt;
  logic [RCW-1:0] eff_rows_r;
  logic [RCW-1:0] eff_rows_nxt;
  logic [PBW-1:0] pair_bytes_r;
  logic [RCW-1:0] rows_m1_r;
  logic [AW-1:0]  last_base_r;
  logic [2:0]     busy_cnt_r;
  logic [2:0]     busy_cnt_nxt;

  // frame position
  logic [CW-1:0]  col_r;
  logic [CW-1:0]  col_nxt;
  logic [RW-1:0]  row_r;
  logic [RW-1:0]  row_nxt;
  logic [AW-1:0]  row_base_r;
  logic [AW-1:0]  row_base_nxt;
  logic           last_col;
  logic           last_row;

  // input stage
  logic           s1_valid_r;
  logic           s1_valid_nxt;
  logic [7:0]     s1_y0_r;
  logic [7:0]     s1_y1_r;
  logic [7:0]     s1_u_r;
  logic [7:0]     s1_v_r;
  logic [AW-1:0]  s1_addr_r;
  logic           s1_end_r;
  logic           s1_adv;
  logic           in_xfer;

  // result stage
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic signed [8:0] s1_u_off;
  logic signed [8:0] s1_v_off;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    if (paddr[2] == y2bgr_pkg::REG_PAIRS) begin
      prdata = {{(32-CFW){1'b0}}, cfg_pairs_r};
    end else begin
      prdata = {{(32-CFW){1'b0}}, cfg_rows_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pairs_r <= y2bgr_pkg::PAIRS_RESET;
      cfg_rows_r  <= y2bgr_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == y2bgr_pkg::REG_PAIRS) begin
        cfg_pairs_r <= pwdata[CFW-1:0];
      end else begin
        cfg_rows_r <= pwdata[CFW-1:0];
      end
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (cfg_pairs_r == '0) begin
      eff_pairs_nxt = PCW'(1);
    end else if (32'(cfg_pairs_r) > 32'(MAX_PAIRS)) begin
      eff_pairs_nxt = PCW'(MAX_PAIRS);
    end else begin
      eff_pairs_nxt = PCW'(cfg_pairs_r);
    end
    if (cfg_rows_r == '0) begin
      eff_rows_nxt = RCW'(1);
    end else if (32'(cfg_rows_r) > 32'(MAX_ROWS)) begin
      eff_rows_nxt = RCW'(MAX_ROWS);
    end else begin
      eff_rows_nxt = RCW'(cfg_rows_r);
    end
  end

  always_ff @(posedge clk) begin
    eff_pairs_r  <= eff_pairs_nxt;
    eff_rows_r   <= eff_rows_nxt;
    pair_bytes_r <= PBW'(eff_pairs_r) * PBW'(6);
    rows_m1_r    <= eff_rows_r - RCW'(1);
    last_base_r  <= AW'(rows_m1_r) * AW'(pair_bytes_r);
  end

  always_comb begin
    if (cfg_wr) begin
      busy_cnt_nxt = y2bgr_pkg::RESTART_CYCLES;
    end else if (busy_cnt_r != 3'd0) begin
      busy_cnt_nxt = busy_cnt_r - 3'd1;
    end else begin
      busy_cnt_nxt = busy_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= y2bgr_pkg::RESTART_CYCLES;
    end else begin
      busy_cnt_r <= busy_cnt_nxt;
    end
  end

  // pipeline control
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = (busy_cnt_r == 3'd0) && (!s1_valid_r || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  assign last_col = (PCW'(col_r) + PCW'(1)) >= eff_pairs_r;
  assign last_row = (RCW'(row_r) + RCW'(1)) >= eff_rows_r;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    if (busy_cnt_r == 3'd1) begin
      col_nxt      = '0;
      row_nxt      = '0;
      row_base_nxt = last_base_r;
    end else if (in_xfer) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt      = '0;
          row_base_nxt = last_base_r;
        end else begin
          row_nxt      = row_r + RW'(1);
          row_base_nxt = row_base_r - AW'(pair_bytes_r);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
    end
  end

  // input register
  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_y0_r   <= in_luma_first;
      s1_u_r    <= in_chroma_blue;
      s1_y1_r   <= in_luma_second;
      s1_v_r    <= in_chroma_red;
      s1_addr_r <= row_base_r + AW'(col_r) * AW'(6);
      s1_end_r  <= last_col && last_row;
    end
  end

  // result register
  assign s1_u_off = y2bgr_pkg::chroma_offset(s1_u_r);
  assign s1_v_off = y2bgr_pkg::chroma_offset(s1_v_r);

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_blue_first   <= y2bgr_pkg::blue_of(s1_y0_r, s1_u_off);
      out_green_first  <= y2bgr_pkg::green_of(s1_y0_r, s1_u_off, s1_v_off);
      out_red_first    <= y2bgr_pkg::red_of(s1_y0_r, s1_v_off);
      out_blue_second  <= y2bgr_pkg::blue_of(s1_y1_r, s1_u_off);
      out_green_second <= y2bgr_pkg::green_of(s1_y1_r, s1_u_off, s1_v_off);
      out_red_second   <= y2bgr_pkg::red_of(s1_y1_r, s1_v_off);
      out_byte_address <= s1_addr_r;
      out_frame_end    <= s1_end_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: dv/yuyv_to_bgr_frame_flip_tb.sv
// Self-checking testbench for the YUYV to BGR converter with flipped frame addressing.
module yuyv_to_bgr_frame_flip_tb;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_PAIRS = 1024;
  localparam int TARGET_PAIRS = 1050;

  // Q2.10 conversion factors
  localparam int K_RV = 1436;
  localparam int K_GU = 352;
  localparam int K_GV = 731;
  localparam int K_BU = 1815;

  typedef struct {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
  } yuyv_pair_t;

  typedef struct {
    logic [7:0]                   b0;
    logic [7:0]                   g0;
    logic [7:0]                   r0;
    logic [7:0]                   b1;
    logic [7:0]                   g1;
    logic [7:0]                   r1;
    logic [y2bgr_pkg::ADDR_W-1:0] addr;
    logic                         fend;
  } bgr_pair_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_luma_first = '0;
  logic [7:0]  in_chroma_blue = '0;
  logic [7:0]  in_luma_second = '0;
  logic [7:0]  in_chroma_red = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_blue_first;
  logic [7:0]  out_green_first;
  logic [7:0]  out_red_first;
  logic [7:0]  out_blue_second;
  logic [7:0]  out_green_second;
  logic [7:0]  out_red_second;
  logic [22:0] out_byte_address;
  logic        out_frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  yuyv_to_bgr_frame_flip #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_PAIRS (MAX_PAIRS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_luma_first    (in_luma_first),
    .in_chroma_blue   (in_chroma_blue),
    .in_luma_second   (in_luma_second),
    .in_chroma_red    (in_chroma_red),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue_first   (out_blue_first),
    .out_green_first  (out_green_first),
    .out_red_first    (out_red_first),
    .out_blue_second  (out_blue_second),
    .out_green_second (out_green_second),
    .out_red_second   (out_red_second),
    .out_byte_address (out_byte_address),
    .out_frame_end    (out_frame_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  yuyv_pair_t  pending_pairs[$];
  bgr_pair_t   expected_bgr[$];
  int unsigned mismatches = 0;
  int unsigned pairs_queued = 0;

  // geometry mirror
  logic [y2bgr_pkg::CFG_W-1:0]  cfg_pairs;
  logic [y2bgr_pkg::CFG_W-1:0]  cfg_rows;
  int unsigned                  row_idx;
  int unsigned                  col_idx;
  logic [y2bgr_pkg::ADDR_W-1:0] row_base;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // zero or negative clamps low; otherwise truncate and clamp high
  function automatic logic [7:0] sat_byte(input int s);
    int q;
    if (s <= 0) return 8'd0;
    q = s / 1024;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic int unsigned eff_size(input logic [y2bgr_pkg::CFG_W-1:0] r,
                                           input int unsigned top);
    if (r == '0) return 1;
    if (r > top) return top;
    return r;
  endfunction

  function automatic void restart_frame();
    int unsigned base;
    base = (eff_size(cfg_rows, MAX_ROWS) - 1) * eff_size(cfg_pairs, MAX_PAIRS) * 6;
    row_idx  = 0;
    col_idx  = 0;
    row_base = base[y2bgr_pkg::ADDR_W-1:0];
  endfunction

  function automatic bgr_pair_t convert_pair(input yuyv_pair_t p);
    bgr_pair_t   res;
    int          cu;
    int          cv;
    int          ys0;
    int          ys1;
    int unsigned pairs;
    int unsigned rows;
    int unsigned offs;
    logic        last_col;
    logic        last_row;
    cu  = int'(p.u) - 128;
    cv  = int'(p.v) - 128;
    ys0 = int'(p.y0) * 1024;
    ys1 = int'(p.y1) * 1024;
    res.b0 = sat_byte(ys0 + K_BU * cu);
    res.g0 = sat_byte(ys0 - K_GU * cu - K_GV * cv);
    res.r0 = sat_byte(ys0 + K_RV * cv);
    res.b1 = sat_byte(ys1 + K_BU * cu);
    res.g1 = sat_byte(ys1 - K_GU * cu - K_GV * cv);
    res.r1 = sat_byte(ys1 + K_RV * cv);
    pairs    = eff_size(cfg_pairs, MAX_PAIRS);
    rows     = eff_size(cfg_rows, MAX_ROWS);
    last_col = (col_idx + 1 >= pairs);
    last_row = (row_idx + 1 >= rows);
    offs     = col_idx * 6;
    res.addr = row_base + offs[y2bgr_pkg::ADDR_W-1:0];
    res.fend = last_col && last_row;
    if (last_col) begin
      col_idx = 0;
      if (last_row) begin
        restart_frame();
      end else begin
        offs     = pairs * 6;
        row_idx  = row_idx + 1;
        row_base = row_base - offs[y2bgr_pkg::ADDR_W-1:0];
      end
    end else begin
      col_idx = col_idx + 1;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_sample();
    logic [7:0] corner[5] = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(0, 9) == 0) return corner[$urandom_range(0, 4)];
    return 8'($urandom());
  endfunction

  // driver
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  always @(posedge clk) begin
    yuyv_pair_t nxt;
    yuyv_pair_t taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.y0 = in_luma_first;
        taken.u  = in_chroma_blue;
        taken.y1 = in_luma_second;
        taken.v  = in_chroma_red;
        expected_bgr.push_back(convert_pair(taken));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          nxt = pending_pairs.pop_front();
          in_luma_first  <= nxt.y0;
          in_chroma_blue <= nxt.u;
          in_luma_second <= nxt.y1;
          in_chroma_red  <= nxt.v;
          in_valid       <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
          end else begin
            in_gap = idle_len();
            if ($urandom_range(0, 99) < 3) in_calm = $urandom_range(20, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result sink
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;
  always @(posedge clk) begin
    bgr_pair_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bgr.size() == 0) begin
          $error("result transfer with no pending expectation (address %0d)",
                 out_byte_address);
          mismatches++;
        end else begin
          want = expected_bgr.pop_front();
          check_field("blue_first", want.b0, out_blue_first);
          check_field("green_first", want.g0, out_green_first);
          check_field("red_first", want.r0, out_red_first);
          check_field("blue_second", want.b1, out_blue_second);
          check_field("green_second", want.g1, out_green_second);
          check_field("red_second", want.r1, out_red_second);
          check_field("byte_address", want.addr, out_byte_address);
          check_field("frame_end", want.fend, out_frame_end);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else if ($urandom_range(0, 3) == 0) begin
          out_stall = idle_len();
          if ($urandom_range(0, 99) < 4) out_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  // sampled between edges so the driver's last transfer is settled
  task automatic drain();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || expected_bgr.size() != 0);
  endtask

  // APB write; any write restarts the frame
  task automatic write_reg(input logic idx, input logic [y2bgr_pkg::CFG_W-1:0] value);
    logic [31:0] word;
    word = $urandom();
    word[y2bgr_pkg::CFG_W-1:0] = value;
    drain();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == y2bgr_pkg::REG_PAIRS) cfg_pairs = value;
    else cfg_rows = value;
    restart_frame();
  endtask

  task automatic push_pair(input logic [7:0] y0, input logic [7:0] u,
                           input logic [7:0] y1, input logic [7:0] v);
    yuyv_pair_t p;
    p.y0 = y0;
    p.u  = u;
    p.y1 = y1;
    p.v  = v;
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) push_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic set_geometry(input logic [y2bgr_pkg::CFG_W-1:0] pairs,
                              input logic [y2bgr_pkg::CFG_W-1:0] rows);
    write_reg(y2bgr_pkg::REG_PAIRS, pairs);
    write_reg(y2bgr_pkg::REG_ROWS, rows);
  endtask

  initial begin
    logic [7:0]                  lvl[3] = '{8'd0, 8'd128, 8'd255};
    logic [y2bgr_pkg::CFG_W-1:0] gp;
    logic [y2bgr_pkg::CFG_W-1:0] gr;
    int unsigned                 pick;
    cfg_pairs = y2bgr_pkg::PAIRS_RESET;
    cfg_rows  = y2bgr_pkg::ROWS_RESET;
    restart_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corner colors under the reset geometry
    for (int y = 0; y < 2; y++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          push_pair(y ? 8'd255 : 8'd0, lvl[a], y ? 8'd0 : 8'd255, lvl[b]);
        end
      end
    end
    push_random(4);

    // tiny frame: wraps at frame end more than once
    set_geometry(11'd2, 11'd2);
    push_random(10);
    // zero acts as one: every pair ends a frame
    set_geometry(11'd0, 11'd0);
    push_random(6);
    // oversize values saturate to the maximum
    set_geometry(11'd2047, 11'd1);
    push_random(40);
    set_geometry(11'd1, 11'd2047);
    push_random(40);
    set_geometry(11'd1024, 11'd1024);
    push_random(30);
    set_geometry(11'd1025, 11'd1025);
    push_random(10);
    // restart in mid-frame via a single register write
    set_geometry(11'd3, 11'd4);
    push_random(5);
    write_reg(y2bgr_pkg::REG_ROWS, 11'd2);
    push_random(9);

    while (pairs_queued < TARGET_PAIRS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        gp = 11'($urandom_range(1, 6));
        gr = 11'($urandom_range(1, 5));
      end else if (pick < 9) begin
        gp = 11'($urandom_range(0, 40));
        gr = 11'($urandom_range(0, 12));
      end else begin
        gp = 11'($urandom_range(0, 2047));
        gr = 11'($urandom_range(0, 2047));
      end
      case ($urandom_range(0, 3))
        0: begin
          write_reg(y2bgr_pkg::REG_PAIRS, gp);
        end
        1: begin
          write_reg(y2bgr_pkg::REG_ROWS, gr);
        end
        default: begin
          set_geometry(gp, gr);
        end
      endcase
      push_random($urandom_range(20, 120));
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_bgr.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
